// ===== hw/rtl/sha1h_pkg.sv =====
// SHA-1 stream hasher package: constants, command/status types, round helpers.
`default_nettype none
package sha1h_pkg;

	localparam int NUM_WORDS  = 5;
	localparam int BLK_BITS   = 512;
	localparam int WORD_BITS  = 32;
	localparam int NUM_ROUNDS = 80;

	localparam logic [31:0] CHAIN_IV [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// byte source for the block intake
	localparam logic [1:0] SRC_IN   = 2'd0;
	localparam logic [1:0] SRC_PAD  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	// round groups of twenty
	localparam logic [1:0] PH_CH   = 2'd0;
	localparam logic [1:0] PH_PAR1 = 2'd1;
	localparam logic [1:0] PH_MAJ  = 2'd2;
	localparam logic [1:0] PH_PAR2 = 2'd3;

	localparam logic [2:0] LAST_IDX = 3'(NUM_WORDS - 1);

	typedef struct packed {
		logic       push;     // shift one byte into the intake block
		logic [1:0] src;      // which byte to shift in
		logic       cnt_inc;  // add eight to the bit count
		logic       load;     // hand the full block to the round engine
		logic       round;    // run one compression round
		logic [1:0] phase;    // round group
		logic       add;      // fold working vars into the chain
		logic       init;     // chain back to initial values
		logic [2:0] out_idx;  // digest word on the output
	} sha1h_cmd_t;

	typedef struct packed {
		logic full;   // intake block complete, not yet taken by the engine
		logic pos56;  // next byte slot is 56
	} sha1h_sts_t;

	function automatic logic [31:0] round_k(input logic [1:0] ph);
		logic [31:0] k;
		case (ph)
			PH_CH:   k = 32'h5A827999;
			PH_PAR1: k = 32'h6ED9EBA1;
			PH_MAJ:  k = 32'h8F1BBCDC;
			default: k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] ph, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (ph)
			PH_CH:   f = (b & c) | (~b & d);
			PH_MAJ:  f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha1h_ifs.sv =====
// Handshake interfaces for the message byte channel and the digest word channel.
`default_nettype none
interface sha1h_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       end_of_message;

	modport source (output valid, data_byte, has_data, end_of_message, input ready);
	modport sink   (input valid, data_byte, has_data, end_of_message, output ready);
endinterface

interface sha1h_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sha1h_dp.sv =====
// SHA-1 datapath: byte intake block, message schedule, round engine, chain words.
`default_nettype none
module sha1h_dp import sha1h_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sha1h_cmd_t  cmd,
	input  wire logic [7:0]  data_byte,
	output      sha1h_sts_t  sts,
	output      logic [31:0] digest_word
);

	logic [BLK_BITS-1:0]  blk_q;   // intake, bytes shift in at the bottom
	logic [BLK_BITS-1:0]  w_q;     // schedule window, W[t] on top
	logic [5:0]           pos_q;
	logic                 full_q;
	logic [63:0]          cnt_q;
	logic [31:0]          a_q, b_q, c_q, d_q, e_q;
	logic [31:0]          h_q [NUM_WORDS];

	logic [7:0]  byte_in;
	logic [31:0] w_new;
	logic [31:0] t_sum;
	logic [31:0] f_val;

	function automatic logic [31:0] w_at(input logic [BLK_BITS-1:0] v, input int i);
		return v[BLK_BITS-1-WORD_BITS*i -: WORD_BITS];
	endfunction

	// byte source select
	always_comb begin
		case (cmd.src)
			SRC_IN:   byte_in = data_byte;
			SRC_PAD:  byte_in = PAD_BYTE;
			SRC_ZERO: byte_in = 8'h00;
			default:  byte_in = cnt_q[63:56];
		endcase
	end

	// next schedule word and round sum
	always_comb begin
		w_new = w_at(w_q, 13) ^ w_at(w_q, 8) ^ w_at(w_q, 2) ^ w_at(w_q, 0);
		w_new = {w_new[30:0], w_new[31]};
		f_val = round_f(cmd.phase, b_q, c_q, d_q);
		t_sum = {a_q[26:0], a_q[31:27]} + f_val + e_q + round_k(cmd.phase) + w_at(w_q, 0);
	end

	// intake block
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[BLK_BITS-9:0], byte_in};
		end
	end

	// position, full flag, bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					full_q <= 1'b1;
				end
			end else if (cmd.load) begin
				full_q <= 1'b0;
			end
			// length bytes shift out, leaving zero for the next message
			if (cmd.push && cmd.src == SRC_LEN) begin
				cnt_q <= {cnt_q[55:0], 8'h00};
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 64'd8;
			end
		end
	end

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= blk_q;
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			w_q <= {w_q[BLK_BITS-WORD_BITS-1:0], w_new};
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// chain words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= CHAIN_IV[i];
			end
		end else if (cmd.init) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= CHAIN_IV[i];
			end
		end else if (cmd.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	// digest word select
	always_comb begin
		case (cmd.out_idx)
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			3'd4:    digest_word = h_q[4];
			default: digest_word = h_q[0];
		endcase
	end

	assign sts.full  = full_q;
	assign sts.pos56 = (pos_q == 6'd56);

endmodule
`default_nettype wire

// ===== hw/rtl/sha1h_ctrl.sv =====
// SHA-1 controller: intake/padding/output sequencer and round engine sequencer.
`default_nettype none
module sha1h_ctrl import sha1h_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_has_data,
	input  wire logic       in_eom,
	output      logic       in_ready,
	output      logic       out_valid,
	input  wire logic       out_ready,
	input  wire sha1h_sts_t sts,
	output      sha1h_cmd_t cmd
);

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_PAD80 = 3'd1;
	localparam logic [2:0] ST_PADZ  = 3'd2;
	localparam logic [2:0] ST_PADL  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [1:0] E_IDLE  = 2'd0;
	localparam logic [1:0] E_ROUND = 2'd1;
	localparam logic [1:0] E_ADD   = 2'd2;

	logic [2:0] st_q, st_d;
	logic [1:0] eng_q, eng_d;
	logic [6:0] rnd_q, rnd_d;
	logic [2:0] len_q, len_d;
	logic [2:0] idx_q, idx_d;
	logic       acc;

	assign in_ready  = (st_q == ST_RUN) && !sts.full;
	assign out_valid = (st_q == ST_OUT);
	assign acc       = in_valid && in_ready;

	// intake, padding and digest output
	always_comb begin
		st_d        = st_q;
		len_d       = len_q;
		idx_d       = idx_q;
		cmd         = '0;
		cmd.out_idx = idx_q;
		unique case (st_q)
			ST_RUN: begin
				cmd.src = SRC_IN;
				if (acc) begin
					cmd.push    = in_has_data;
					cmd.cnt_inc = in_has_data;
					if (in_eom) begin
						st_d = ST_PAD80;
					end
				end
			end
			ST_PAD80: begin
				cmd.src = SRC_PAD;
				if (!sts.full) begin
					cmd.push = 1'b1;
					st_d     = ST_PADZ;
				end
			end
			ST_PADZ: begin
				cmd.src = SRC_ZERO;
				if (!sts.full) begin
					if (sts.pos56) begin
						st_d  = ST_PADL;
						len_d = '0;
					end else begin
						cmd.push = 1'b1;
					end
				end
			end
			ST_PADL: begin
				cmd.src = SRC_LEN;
				if (!sts.full) begin
					cmd.push = 1'b1;
					len_d    = len_q + 3'd1;
					if (len_q == 3'd7) begin
						st_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!sts.full && eng_q == E_IDLE) begin
					st_d  = ST_OUT;
					idx_d = '0;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					if (idx_q == LAST_IDX) begin
						cmd.init = 1'b1;
						st_d     = ST_RUN;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: st_d = ST_RUN;
		endcase

		// round engine
		eng_d = eng_q;
		rnd_d = rnd_q;
		if (rnd_q < 7'd20) begin
			cmd.phase = PH_CH;
		end else if (rnd_q < 7'd40) begin
			cmd.phase = PH_PAR1;
		end else if (rnd_q < 7'd60) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end
		unique case (eng_q)
			E_IDLE: begin
				if (sts.full) begin
					cmd.load = 1'b1;
					rnd_d    = '0;
					eng_d    = E_ROUND;
				end
			end
			E_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 7'd1;
				if (rnd_q == 7'(NUM_ROUNDS - 1)) begin
					eng_d = E_ADD;
				end
			end
			E_ADD: begin
				cmd.add = 1'b1;
				eng_d   = E_IDLE;
			end
			default: eng_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_RUN;
			eng_q <= E_IDLE;
			rnd_q <= '0;
			len_q <= '0;
			idx_q <= '0;
		end else begin
			st_q  <= st_d;
			eng_q <= eng_d;
			rnd_q <= rnd_d;
			len_q <= len_d;
			idx_q <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sha1_stream_hasher.sv =====
// SHA-1 stream hasher top level: controller plus datapath.
//
//   channel  dir  payload                                 handshake
//   msg      in   data_byte[8], has_data, end_of_message  valid/ready
//   digest   out  digest_word[32], word_index[3], last_word valid/ready
//
// Every 64 bytes a block goes to the round engine: a load, 80 rounds at one per cycle
// and a chain add, while the next block fills; intake stalls while that block is full,
// and during padding and digest output. A final item pads one byte per cycle while the
// block is not full (9 to 72 bytes, pausing once before the length field) with one or
// two compressions, then shows five digest words, one per accepted cycle; no message byte
// is taken until the fifth is taken. Asynchronous reset loads the initial chain.
`default_nettype none
module sha1_stream_hasher import sha1h_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	sha1h_in_if.sink    msg,
	sha1h_out_if.source digest
);

	sha1h_cmd_t cmd;
	sha1h_sts_t sts;

	sha1h_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (msg.valid),
		.in_has_data (msg.has_data),
		.in_eom      (msg.end_of_message),
		.in_ready    (msg.ready),
		.out_valid   (digest.valid),
		.out_ready   (digest.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	sha1h_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.sts         (sts),
		.digest_word (digest.digest_word)
	);

	assign digest.word_index = cmd.out_idx;
	assign digest.last_word  = (cmd.out_idx == LAST_IDX);

endmodule
`default_nettype wire

// ===== hw/rtl/sha1h_chk.sv =====
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
`default_nettype none
module sha1h_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);

	// a stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest item changed while stalled");

	// words come out in order with no gap
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest word index did not step");

	// last flag marks word four only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last_word does not match word_index");

	// no byte taken while a digest is shown
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while digest pending");

endmodule

bind sha1_stream_hasher sha1h_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (msg.ready),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.word_index  (digest.word_index),
	.last_word   (digest.last_word)
);
`default_nettype wire

// ===== sim/sha1h_checker.sv =====
// Digest checker: predicts SHA-1 digests from accepted message items and compares output words.
module sha1h_checker (
	input wire logic clk,
	input wire logic arst_n,
	sha1h_in_if      msg,
	sha1h_out_if     digest,
	output int       mismatch_count,
	output int       pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [5:0] LEN_SLOT     = 6'd56;
	localparam int         REPORT_LIMIT = 10;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	// running hash state
	logic [31:0]  chain [5];
	logic [31:0]  block [16];
	logic [5:0]   byte_pos;
	logic [63:0]  bit_count;
	digest_word_t expected_words [$];

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// 80-round compression of the current block into the chain
	function automatic void compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = block[r];
		for (int r = 16; r < 80; r++)
			w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	// big-endian byte packing; a full block is compressed right away
	function automatic void absorb_byte(input logic [7:0] v);
		logic [3:0] wi;
		int         shift;
		wi = byte_pos[5:2];
		shift = (3 - int'(byte_pos[1:0])) * 8;
		if (byte_pos[1:0] == 2'd0)
			block[wi] = 32'h0;
		block[wi] |= 32'(v) << shift;
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == 6'd0)
			compress();
	endfunction

	function automatic void restart();
		chain = SHA1_IV;
		byte_pos = 6'd0;
		bit_count = 64'd0;
	endfunction

	// one accepted message item; a final item pads and queues five words
	function automatic void absorb_item(input logic [7:0] data, input logic hd, input logic eom);
		logic [63:0]  len_bits;
		digest_word_t dw;
		if (hd) begin
			absorb_byte(data);
			bit_count += 64'd8;
		end
		if (eom) begin
			len_bits = bit_count;
			absorb_byte(PAD_MARK);
			while (byte_pos != LEN_SLOT)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(len_bits[63 - 8*i -: 8]);
			for (int i = 0; i < 5; i++) begin
				dw.word = chain[i];
				dw.index = 3'(i);
				dw.last = (i == 4);
				expected_words.push_back(dw);
			end
			restart();
		end
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin
		digest_word_t got, want;
		if (!arst_n) begin
			restart();
			expected_words.delete();
			mismatch_count = 0;
			pending_words = 0;
		end else begin
			if (digest.valid && digest.ready) begin
				got.word = digest.digest_word;
				got.index = digest.word_index;
				got.last = digest.last_word;
				if (expected_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected digest word %h index %0d last %b",
							got.word, got.index, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got.word !== want.word || got.index !== want.index ||
							got.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
								want.word, want.index, want.last,
								got.word, got.index, got.last);
					end
				end
			end
			if (msg.valid && msg.ready)
				absorb_item(msg.data_byte, msg.has_data, msg.end_of_message);
			pending_words = expected_words.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the SHA-1 stream hasher: clock, reset, message stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 330;
	localparam int MIN_MESSAGES = 10;
	localparam int DRAIN_CYCLES = 300;
	localparam int EDGE_LEN [12] = '{55, 56, 57, 62, 63, 64, 65, 118, 119, 120, 127, 128};

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   sent_items;
	int   messages_done;
	bit   quiet;

	sha1h_in_if  msg_if();
	sha1h_out_if dig_if();

	sha1_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (dig_if)
	);

	sha1h_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg            (msg_if),
		.digest         (dig_if),
		.mismatch_count (mismatches),
		.pending_words  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, now and then a long one; none in quiet stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 150);
	endfunction

	// message lengths lean on the padding and block boundaries
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return $urandom_range(0, 8);
		if (r < 13)
			return EDGE_LEN[$urandom_range(0, 11)];
		if (r < 19)
			return $urandom_range(0, 100);
		return $urandom_range(129, 200);
	endfunction

	// present one item at the falling edge and hold it until accepted
	task automatic send_item(input logic [7:0] b, input logic hd, input logic eom);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			msg_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.data_byte <= b;
		msg_if.has_data <= hd;
		msg_if.end_of_message <= eom;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	// hold off the sender until every digest word is out
	task automatic wait_for_digests();
		msg_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_message(input int len, input bit split_final, input bit with_idles,
			input fill_t fill);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (with_idles && $urandom_range(0, 7) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom);
			endcase
			send_item(b, 1'b1, !split_final && i == len - 1);
		end
		if (split_final || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
		messages_done++;
	endtask

	// digest side: random stalls with runs of ready in between
	initial begin
		int n;
		dig_if.ready = 1'b0;
		@(negedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				dig_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			dig_if.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int    r;
		fill_t fill;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.data_byte = 8'h00;
		msg_if.has_data = 1'b0;
		msg_if.end_of_message = 1'b0;
		sent_items = 0;
		messages_done = 0;
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle item before anything, then the empty message
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		// "abc", final flag on the last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// extreme bytes with an idle item in between
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// final item without data after two bytes
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		wait_for_digests();

		// random messages
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS || messages_done < MIN_MESSAGES) begin
			quiet = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) == 0)
				wait_for_digests();
			r = $urandom_range(0, 7);
			fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
			send_message(pick_length(), $urandom_range(0, 2) == 0,
				$urandom_range(0, 3) == 0, fill);
		end
		quiet = 1'b0;

		// drain, then give any stray word time to show up
		msg_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("sha1_stream_hasher regression: pass");
		else
			$display("sha1_stream_hasher regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("sha1_stream_hasher regression: fail");
		$finish;
	end

endmodule
